### rtl/core/m2q_pkg.sv
package m2q_pkg;

  localparam int unsigned ElemW = 16;
  localparam int unsigned QuatW = 17;
  localparam int unsigned IdxW  = 2;

  localparam logic [IdxW-1:0] SelW = 2'd0;
  localparam logic [IdxW-1:0] SelX = 2'd1;
  localparam logic [IdxW-1:0] SelY = 2'd2;
  localparam logic [IdxW-1:0] SelZ = 2'd3;

  localparam logic signed [QuatW-1:0] QuatMax = 17'sd65535;
  localparam logic signed [QuatW-1:0] QuatMin = -17'sd65536;

endpackage

### rtl/core/matrix_to_quaternion.sv
// Channel  Dir  tdata fields (low bit first)                     tuser/tlast
// s_axis   in   elem_r1c1..elem_r3c3, 9 x 16 bits (144)           none
// m_axis   out  quat_w,quat_x,quat_y,quat_z 17 bits each, pad 72   largest_index
// One item enters per cycle while s_axis_tready is high; at FRAC_BITS 14 a
// result passes a front register, the queue, a load stage and 17
// square root stages, a rounding stage, a load stage and 32 divider stages,
// and an output register. The stage counts grow with FRAC_BITS.
// Reset clears all valid flags; data registers are not reset.
// A stall at m_axis freezes the back pipeline; the queue lets the front keep
// accepting until it fills.
module matrix_to_quaternion
  import m2q_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [9*ElemW-1:0]      s_axis_tdata,  // elem_r1c1 .. elem_r3c3
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [71:0]             m_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic [IdxW-1:0]         m_axis_tuser   // largest_index
);

  localparam int unsigned DiffW = 18;
  localparam int unsigned RadW  = ElemW + 4 + (FRAC_BITS > 14 ? FRAC_BITS - 14 : 0);
  localparam int unsigned QW    = RadW + 3 * DiffW + IdxW;

  logic            f_valid, f_ready, q_valid, q_ready;
  logic [QW-1:0]   f_data, q_data;
  logic [4*QuatW+IdxW-1:0] b_data;
  logic [RadW-1:0] one_sh;

  assign one_sh = RadW'(1) << FRAC_BITS;

  m2q_front #(.DiffW(DiffW), .RadW(RadW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),  .one_sh_i   (one_sh),
    .out_valid_o(f_valid), .out_ready_i(f_ready), .out_data_o(f_data)
  );

  m2q_fifo #(.Width(QW), .Depth(4)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_data),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_data)
  );

  m2q_back #(.FracBits(FRAC_BITS), .DiffW(DiffW), .RadW(RadW)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(q_data),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(b_data)
  );

  assign m_axis_tdata = {4'b0, b_data[4*QuatW-1:0]};
  assign m_axis_tuser = b_data[4*QuatW +: IdxW];

endmodule

### rtl/core/m2q_fifo.sv
module m2q_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != (PtrW+1)'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(Depth)) else $error("queue count overflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on write");
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> !do_rd) else $error("queue read while empty");

endmodule

### rtl/core/m2q_front.sv
module m2q_front
  import m2q_pkg::*;
#(
  parameter int unsigned DiffW = 18,
  parameter int unsigned RadW  = 34
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [9*ElemW-1:0]      in_data_i,
  input  logic [RadW-1:0]         one_sh_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [RadW+3*DiffW+IdxW-1:0] out_data_o
);

  logic signed [ElemW-1:0] m [9];
  logic signed [ElemW+1:0] cand [4];
  logic signed [ElemW+1:0] best;
  logic [IdxW-1:0]         sel;
  logic signed [ElemW:0]   dwx, dwy, dwz, sxy, sxz, syz;
  logic signed [DiffW-1:0] d0, d1, d2;
  logic [RadW-1:0]         rad;
  logic                    valid_q;
  logic [RadW+3*DiffW+IdxW-1:0] data_q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = in_data_i[i*ElemW +: ElemW];
    end
    cand[0] = 18'(m[0]) + 18'(m[4]) + 18'(m[8]);
    cand[1] = 18'(m[0]) - 18'(m[4]) - 18'(m[8]);
    cand[2] = 18'(m[4]) - 18'(m[0]) - 18'(m[8]);
    cand[3] = 18'(m[8]) - 18'(m[0]) - 18'(m[4]);
    best = cand[0];
    sel  = SelW;
    for (int k = 1; k < 4; k++) begin
      if (cand[k] > best) begin
        best = cand[k];
        sel  = IdxW'(k);
      end
    end
    dwx = 17'(m[7]) - 17'(m[5]);
    dwy = 17'(m[2]) - 17'(m[6]);
    dwz = 17'(m[3]) - 17'(m[1]);
    sxy = 17'(m[3]) + 17'(m[1]);
    sxz = 17'(m[2]) + 17'(m[6]);
    syz = 17'(m[7]) + 17'(m[5]);
    unique case (sel)
      SelW: begin d0 = DiffW'(dwx); d1 = DiffW'(dwy); d2 = DiffW'(dwz); end
      SelX: begin d0 = DiffW'(dwx); d1 = DiffW'(sxy); d2 = DiffW'(sxz); end
      SelY: begin d0 = DiffW'(dwy); d1 = DiffW'(sxy); d2 = DiffW'(syz); end
      default: begin d0 = DiffW'(dwz); d1 = DiffW'(sxz); d2 = DiffW'(syz); end
    endcase
    rad = (RadW'($unsigned(best)) << 0) + one_sh_i;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= {sel, d2, d1, d0, rad};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

endmodule

### rtl/core/m2q_back.sv
module m2q_back
  import m2q_pkg::*;
#(
  parameter int unsigned FracBits = 14,
  parameter int unsigned DiffW    = 18,
  parameter int unsigned RadW     = 34
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [RadW+3*DiffW+IdxW-1:0] in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [4*QuatW+IdxW-1:0] out_data_o
);

  // Radicand is (c + one) << F, square root pipeline one result bit per stage.
  localparam int unsigned SqW   = RadW + FracBits;
  localparam int unsigned RootW = (SqW + 1) / 2;
  localparam int unsigned VW    = RootW;
  localparam int unsigned NumW  = DiffW + FracBits;
  localparam int unsigned DenW  = VW + 2;
  localparam int unsigned QW    = NumW;
  localparam int unsigned RStg  = RootW;
  localparam int unsigned DStg  = QW;
  localparam int unsigned NStg  = RStg + DStg + 3;

  typedef struct packed {
    logic [IdxW-1:0]  sel;
    logic [2:0]       neg;
    logic [NumW-1:0]  n0, n1, n2;
  } side_t;

  logic          adv;
  logic [NStg:0] vld_q;

  logic [SqW-1:0]   sq_x_q  [RStg+1];
  logic [RootW-1:0] sq_r_q  [RStg+1];
  side_t            sq_s_q  [RStg+1];

  logic [VW-1:0]    v_q;
  logic [DenW-1:0]  den_q;
  side_t            vs_q;

  logic [NumW+DenW-1:0] dv_rem_q [3][DStg+1];
  logic [QW-1:0]        dv_quo_q [3][DStg+1];
  logic [DenW-1:0]      dv_den_q [DStg+1];
  logic [VW-1:0]        dv_v_q   [DStg+1];
  side_t                dv_s_q   [DStg+1];

  logic [4*QuatW+IdxW-1:0] res_q;

  logic [RadW-1:0]       rad_in;
  logic [DiffW-1:0]      din [3];
  side_t                 s_in;

  assign adv        = !vld_q[NStg] || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[NStg];
  assign out_data_o  = res_q;

  always_comb begin
    rad_in = in_data_i[RadW-1:0];
    for (int i = 0; i < 3; i++) begin
      din[i] = in_data_i[RadW + i*DiffW +: DiffW];
    end
    s_in.sel = in_data_i[RadW+3*DiffW +: IdxW];
    for (int i = 0; i < 3; i++) begin
      s_in.neg[i] = din[i][DiffW-1];
    end
    s_in.n0 = NumW'(din[0][DiffW-1] ? -din[0] : din[0]) << FracBits;
    s_in.n1 = NumW'(din[1][DiffW-1] ? -din[1] : din[1]) << FracBits;
    s_in.n2 = NumW'(din[2][DiffW-1] ? -din[2] : din[2]) << FracBits;
  end

  function automatic logic signed [QuatW-1:0] sat_mag(input logic [QW-1:0] mag,
                                                      input logic neg);
    logic [QW:0] lim;
    lim = neg ? (QW+1)'(65536) : (QW+1)'(65535);
    if ({1'b0, mag} > lim) begin
      sat_mag = neg ? QuatMin : QuatMax;
    end else begin
      sat_mag = neg ? QuatW'(-$signed({1'b0, mag})) : QuatW'(mag);
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_x_q[0] <= SqW'(rad_in) << FracBits;
      sq_r_q[0] <= '0;
      sq_s_q[0] <= s_in;
      for (int k = 0; k < RStg; k++) begin
        logic [SqW+1:0] trial;
        logic [SqW-1:0] bitv;
        bitv  = SqW'(1) << (2 * (RStg - 1 - k));
        trial = (SqW+2)'({sq_r_q[k], 1'b0}) << (RStg - 1 - k);
        trial = trial + (SqW+2)'(bitv);
        if ((SqW+2)'(sq_x_q[k]) >= trial) begin
          sq_x_q[k+1] <= sq_x_q[k] - SqW'(trial);
          sq_r_q[k+1] <= sq_r_q[k] | (RootW'(1) << (RStg - 1 - k));
        end else begin
          sq_x_q[k+1] <= sq_x_q[k];
          sq_r_q[k+1] <= sq_r_q[k];
        end
        sq_s_q[k+1] <= sq_s_q[k];
      end
      v_q   <= VW'(({1'b0, sq_r_q[RStg]} + 1'b1) >> 1);
      den_q <= DenW'(({1'b0, sq_r_q[RStg]} + 1'b1) >> 1) << 2;
      vs_q  <= sq_s_q[RStg];
      dv_den_q[0] <= den_q;
      dv_v_q[0]   <= v_q;
      dv_s_q[0]   <= vs_q;
      dv_rem_q[0][0] <= (NumW+DenW)'(vs_q.n0) + (NumW+DenW)'(den_q >> 1);
      dv_rem_q[1][0] <= (NumW+DenW)'(vs_q.n1) + (NumW+DenW)'(den_q >> 1);
      dv_rem_q[2][0] <= (NumW+DenW)'(vs_q.n2) + (NumW+DenW)'(den_q >> 1);
      for (int j = 0; j < 3; j++) begin
        dv_quo_q[j][0] <= '0;
      end
      for (int k = 0; k < DStg; k++) begin
        for (int j = 0; j < 3; j++) begin
          logic [NumW+DenW+QW-1:0] sd;
          sd = (NumW+DenW+QW)'(dv_den_q[k]) << (DStg - 1 - k);
          if ((NumW+DenW+QW)'(dv_rem_q[j][k]) >= sd) begin
            dv_rem_q[j][k+1] <= dv_rem_q[j][k] - (NumW+DenW)'(sd);
            dv_quo_q[j][k+1] <= dv_quo_q[j][k] | (QW'(1) << (DStg - 1 - k));
          end else begin
            dv_rem_q[j][k+1] <= dv_rem_q[j][k];
            dv_quo_q[j][k+1] <= dv_quo_q[j][k];
          end
        end
        dv_den_q[k+1] <= dv_den_q[k];
        dv_v_q[k+1]   <= dv_v_q[k];
        dv_s_q[k+1]   <= dv_s_q[k];
      end
      begin
        logic signed [QuatW-1:0] vv, a0, a1, a2;
        side_t s;
        s  = dv_s_q[DStg];
        vv = sat_mag(QW'(dv_v_q[DStg]), 1'b0);
        a0 = sat_mag(dv_quo_q[0][DStg], s.neg[0]);
        a1 = sat_mag(dv_quo_q[1][DStg], s.neg[1]);
        a2 = sat_mag(dv_quo_q[2][DStg], s.neg[2]);
        unique case (s.sel)
          SelW: res_q <= {s.sel, a2, a1, a0, vv};
          SelX: res_q <= {s.sel, a2, a1, vv, a0};
          SelY: res_q <= {s.sel, a2, vv, a1, a0};
          default: res_q <= {s.sel, vv, a2, a1, a0};
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-1:0], in_valid_i};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(res_q))
    else $error("result changed while stalled");
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q == $past(vld_q)) else $error("pipeline moved while stalled");
  a_v_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[RStg+1] |-> v_q >= VW'(1 << (FracBits - 1)))
    else $error("selected component below one half");

endmodule
